// File: src/cfdc_pkg.sv
// shared types, constants and the crc step for the can frame datagram checker
`timescale 1ns / 1ps
package cfdc_pkg;

    // header layout and check constants
    localparam int          HDR_LEN    = 10;
    localparam logic [15:0] MAGIC_WORD = 16'h2934;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  FD_MASK    = 8'h01;

    // header byte positions
    localparam logic [6:0] POS_MAGIC_LO = 7'd0;
    localparam logic [6:0] POS_MAGIC_HI = 7'd1;
    localparam logic [6:0] POS_CRC_LO   = 7'd2;
    localparam logic [6:0] POS_CRC_HI   = 7'd3;
    localparam logic [6:0] POS_FLAGS    = 7'd4;
    localparam logic [6:0] POS_ID_LO    = 7'd6;
    localparam logic [6:0] POS_ID_HI    = 7'd9;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_MAGIC = 2'd2,
        ST_BAD_CRC   = 2'd3
    } t_status;

    // one finished datagram, handed from the front to the back
    typedef struct packed {
        t_status     status;
        logic [31:0] id;
        logic        fd;
        logic [6:0]  plen;
        logic        bank;
    } t_desc;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/can_frame_datagram_checker_top.sv
// top level of the can frame datagram checker
`timescale 1ns / 1ps
//  channel | dir | handshake               | tdata / tuser / tlast
//  s       | in  | i_s_tvalid, o_s_tready  | tdata byte_in, tlast end_of_datagram
//  m       | out | o_m_tvalid, i_m_tready  | tdata id/fd/length/byte/pos, tuser status,
//          |     |                         | tlast final_result
//
//  the front takes one byte per cycle while o_s_tready is high and decides the
//  frame on its final byte; the back emits one result per cycle while i_m_tready
//  is high, from a two-bank payload memory through memory read and output register
//  a datagram with n data bytes drains as n results (one for a status result)
//  o_s_tready drops while two finished datagrams wait in the descriptor queue
//  reset is synchronous and active low; the payload memory is not cleared
module can_frame_datagram_checker_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] byte_in
    input  logic        i_s_tlast,  // end_of_datagram
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // [31:0] frame_id, [32] fd_frame,
                                    // [39:33] payload_length, [47:40] payload_byte,
                                    // [53:48] byte_position, [55:54] zero
    output logic [1:0]  o_m_tuser,  // [1:0] status
    output logic        o_m_tlast   // final_result
);
    import cfdc_pkg::*;

    localparam int IW = $clog2(MAX_PAYLOAD);

    logic          wr_en;
    logic [IW:0]   wr_addr;
    logic [7:0]    wr_data;
    logic          push;
    logic          pop;
    logic          avail;
    logic          full;
    t_desc         desc;
    t_desc         head;

    logic [1:0]    status;
    logic [31:0]   id;
    logic          fd;
    logic [6:0]    plen;
    logic [7:0]    pbyte;
    logic [5:0]    pos;

    assign o_s_tready = ~full;

    cfdc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (push),
        .o_desc    (desc)
    );

    cfdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_avail (avail),
        .o_full  (full)
    );

    cfdc_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_head    (head),
        .i_avail   (avail),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_status  (status),
        .o_id      (id),
        .o_fd      (fd),
        .o_plen    (plen),
        .o_byte    (pbyte),
        .o_pos     (pos),
        .o_fin     (o_m_tlast)
    );

    // result packing
    assign o_m_tdata = {2'b00, pos, pbyte, plen, fd, id};
    assign o_m_tuser = status;

endmodule

// File: src/cfdc_front.sv
// front end: header parse, running crc, payload write and frame verdict
`timescale 1ns / 1ps
module cfdc_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_ready,
    input  logic [7:0]                          i_byte,
    input  logic                                i_last,
    output logic                                o_wr_en,
    output logic [$clog2(MAX_PAYLOAD):0]        o_wr_addr,
    output logic [7:0]                          o_wr_data,
    output logic                                o_push,
    output cfdc_pkg::t_desc                     o_desc
);
    import cfdc_pkg::*;

    localparam int          IW    = $clog2(MAX_PAYLOAD);
    localparam logic [6:0]  LIMIT = 7'(MAX_PAYLOAD + HDR_LEN);
    localparam logic [6:0]  HDR7  = 7'(HDR_LEN);

    logic [6:0]  r_seen,  n_seen;
    logic [15:0] r_magic, n_magic;
    logic [15:0] r_rxcrc, n_rxcrc;
    logic [15:0] r_crc,   n_crc;
    logic        r_fd,    n_fd;
    logic [31:0] r_id,    n_id;
    logic        r_bank;

    logic       acc;
    logic       keep;
    logic [6:0] pidx;
    logic [6:0] id_sh;

    assign acc   = i_valid & i_ready;
    assign keep  = r_seen < LIMIT;
    assign pidx  = r_seen - HDR7;
    assign id_sh = r_seen - POS_ID_LO;

    // header capture and crc over the kept bytes past the crc field
    always_comb begin
        n_seen  = r_seen;
        n_magic = r_magic;
        n_rxcrc = r_rxcrc;
        n_crc   = r_crc;
        n_fd    = r_fd;
        n_id    = r_id;
        if (keep) begin
            n_seen = r_seen + 7'd1;
            if (r_seen == POS_MAGIC_LO) begin
                n_magic[7:0] = i_byte;
            end else if (r_seen == POS_MAGIC_HI) begin
                n_magic[15:8] = i_byte;
            end else if (r_seen == POS_CRC_LO) begin
                n_rxcrc[7:0] = i_byte;
            end else if (r_seen == POS_CRC_HI) begin
                n_rxcrc[15:8] = i_byte;
            end else begin
                n_crc = crc_byte(r_crc, i_byte);
                if (r_seen == POS_FLAGS) begin
                    n_fd = |(i_byte & FD_MASK);
                end else if (r_seen >= POS_ID_LO && r_seen <= POS_ID_HI) begin
                    n_id[8*id_sh[1:0] +: 8] = i_byte;
                end
            end
        end
    end

    // payload byte into the current bank
    assign o_wr_en   = acc & keep & (r_seen >= HDR7);
    assign o_wr_addr = {r_bank, pidx[IW-1:0]};
    assign o_wr_data = i_byte;

    // verdict on the final byte
    always_comb begin
        o_desc.id   = 32'd0;
        o_desc.fd   = 1'b0;
        o_desc.plen = 7'd0;
        o_desc.bank = r_bank;
        if (n_seen < HDR7) begin
            o_desc.status = ST_SHORT;
        end else if (n_magic != MAGIC_WORD) begin
            o_desc.status = ST_BAD_MAGIC;
        end else if (n_rxcrc != n_crc) begin
            o_desc.status = ST_BAD_CRC;
        end else begin
            o_desc.status = ST_OK;
            o_desc.id     = n_id;
            o_desc.fd     = n_fd;
            o_desc.plen   = n_seen - HDR7;
        end
    end

    assign o_push = acc & i_last;

    // per-datagram state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 7'd0;
            r_magic <= 16'd0;
            r_rxcrc <= 16'd0;
            r_crc   <= CRC_INIT;
            r_fd    <= 1'b0;
            r_id    <= 32'd0;
            r_bank  <= 1'b0;
        end else if (acc) begin
            if (i_last) begin
                r_seen  <= 7'd0;
                r_magic <= 16'd0;
                r_rxcrc <= 16'd0;
                r_crc   <= CRC_INIT;
                r_fd    <= 1'b0;
                r_id    <= 32'd0;
                r_bank  <= ~r_bank;
            end else begin
                r_seen  <= n_seen;
                r_magic <= n_magic;
                r_rxcrc <= n_rxcrc;
                r_crc   <= n_crc;
                r_fd    <= n_fd;
                r_id    <= n_id;
            end
        end
    end

    // byte count never runs past the kept length
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= LIMIT)
        else $error("front byte count beyond limit");

endmodule

// File: src/cfdc_queue.sv
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps
module cfdc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfdc_pkg::t_desc i_desc,
    input  logic            i_pop,
    output cfdc_pkg::t_desc o_head,
    output logic            o_avail,
    output logic            o_full
);
    import cfdc_pkg::*;

    t_desc      r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head  = r_ent[r_rp];
    assign o_avail = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("descriptor pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_avail))
        else $error("descriptor popped from empty queue");

endmodule

// File: src/cfdc_back.sv
// back end: payload memory, result sequencing and output register
`timescale 1ns / 1ps
module cfdc_back #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_PAYLOAD):0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  cfdc_pkg::t_desc              i_head,
    input  logic                         i_avail,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [31:0]                  o_id,
    output logic                         o_fd,
    output logic [6:0]                   o_plen,
    output logic [7:0]                   o_byte,
    output logic [5:0]                   o_pos,
    output logic                         o_fin
);
    import cfdc_pkg::*;

    localparam int IW = $clog2(MAX_PAYLOAD);

    // two banks so one datagram fills while the other drains
    logic [7:0] r_mem [2**(IW+1)];

    logic [IW-1:0] r_idx;
    logic          issue;
    logic          fin;
    logic          out_slot;
    logic          s1_ready;

    // read stage
    logic          r_s1_vld;
    logic [7:0]    r_rd_data;
    logic [1:0]    r_s1_status;
    logic [31:0]   r_s1_id;
    logic          r_s1_fd;
    logic [6:0]    r_s1_plen;
    logic          r_s1_use;
    logic [5:0]    r_s1_pos;
    logic          r_s1_fin;

    // output register
    logic          r_o_vld;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_id;
    logic          r_o_fd;
    logic [6:0]    r_o_plen;
    logic [7:0]    r_o_byte;
    logic [5:0]    r_o_pos;
    logic          r_o_fin;

    assign out_slot = !r_o_vld || i_ready;
    assign s1_ready = !r_s1_vld || out_slot;
    assign issue    = i_avail && s1_ready;
    assign fin      = (i_head.status != ST_OK) || (i_head.plen == 7'd0) ||
                      ((7'(r_idx) + 7'd1) == i_head.plen);
    assign o_pop    = issue && fin;

    // payload memory
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{i_head.bank, r_idx}];
        end
    end

    // result index within the current datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= fin ? '0 : r_idx + 1'b1;
        end
    end

    // read stage fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue || (r_s1_vld && !out_slot);
        end
        if (issue) begin
            r_s1_status <= i_head.status;
            r_s1_id     <= i_head.id;
            r_s1_fd     <= i_head.fd;
            r_s1_plen   <= i_head.plen;
            r_s1_use    <= (i_head.status == ST_OK) && (i_head.plen != 7'd0);
            r_s1_pos    <= 6'(r_idx);
            r_s1_fin    <= fin;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_slot) begin
            r_o_vld <= r_s1_vld;
        end
        if (out_slot && r_s1_vld) begin
            r_o_status <= r_s1_status;
            r_o_id     <= r_s1_id;
            r_o_fd     <= r_s1_fd;
            r_o_plen   <= r_s1_plen;
            r_o_byte   <= r_s1_use ? r_rd_data : 8'd0;
            r_o_pos    <= r_s1_pos;
            r_o_fin    <= r_s1_fin;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_status = r_o_status;
    assign o_id     = r_o_id;
    assign o_fd     = r_o_fd;
    assign o_plen   = r_o_plen;
    assign o_byte   = r_o_byte;
    assign o_pos    = r_o_pos;
    assign o_fin    = r_o_fin;

    // a held read stage stays full while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_slot) |=> r_s1_vld)
        else $error("read stage dropped while output stalled");

    // an error status is always the only result of its datagram
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && i_head.status != ST_OK) |-> o_pop)
        else $error("error status without pop");

endmodule
